// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Expression that must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/fpr_pkg.sv =====
// Shared constants, command codes and interface structs of the frame receiver.
`default_nettype none

package fpr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 6;
  localparam int INDEX_W     = 5;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_VALUE = 1'b1;

  localparam logic [2:0] OP_IDLE    = 3'd0;
  localparam logic [2:0] OP_HEADER  = 3'd1;
  localparam logic [2:0] OP_ADDRESS = 3'd2;
  localparam logic [2:0] OP_LENGTH  = 3'd3;
  localparam logic [2:0] OP_COMMAND = 3'd4;
  localparam logic [2:0] OP_PAYLOAD = 3'd5;
  localparam logic [2:0] OP_CHECK   = 3'd6;

  typedef struct packed {
    logic       take;
    logic [2:0] op;
    logic       mem_read;
    logic       flush_load;
  } cmd_t;

  typedef struct packed {
    logic header_match;
    logic address_ok;
    logic length_ok;
    logic length_is_one;
    logic payload_done;
    logic sum_match;
    logic out_busy;
    logic out_free;
    logic flush_last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/fpr_ctrl.sv =====
// Frame phase state machine that sequences reception and the payload flush.
`default_nettype none

module fpr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  fpr_pkg::status_t     st,
  output fpr_pkg::cmd_t        cmd,
  output logic                 in_stall
);

  localparam logic [2:0] S_HEADER  = 3'd0;
  localparam logic [2:0] S_ADDRESS = 3'd1;
  localparam logic [2:0] S_LENGTH  = 3'd2;
  localparam logic [2:0] S_COMMAND = 3'd3;
  localparam logic [2:0] S_PAYLOAD = 3'd4;
  localparam logic [2:0] S_CHECK   = 3'd5;
  localparam logic [2:0] S_FL_READ = 3'd6;
  localparam logic [2:0] S_FL_LOAD = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b0;
    unique case (state)
      S_HEADER: begin
        cmd.op = fpr_pkg::OP_HEADER;
        if (in_valid && st.header_match) state_next = S_ADDRESS;
      end
      S_ADDRESS: begin
        cmd.op = fpr_pkg::OP_ADDRESS;
        if (in_valid) state_next = st.address_ok ? S_LENGTH : S_HEADER;
      end
      S_LENGTH: begin
        cmd.op = fpr_pkg::OP_LENGTH;
        if (in_valid) state_next = st.length_ok ? S_COMMAND : S_HEADER;
      end
      S_COMMAND: begin
        cmd.op = fpr_pkg::OP_COMMAND;
        if (in_valid) state_next = st.length_is_one ? S_CHECK : S_PAYLOAD;
      end
      S_PAYLOAD: begin
        cmd.op = fpr_pkg::OP_PAYLOAD;
        if (in_valid && st.payload_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op   = fpr_pkg::OP_CHECK;
        in_stall = st.out_busy;
        if (in_valid && !st.out_busy) begin
          state_next = (st.sum_match && !st.length_is_one) ? S_FL_READ : S_HEADER;
        end
      end
      S_FL_READ: begin
        in_stall     = 1'b1;
        cmd.mem_read = 1'b1;
        state_next   = S_FL_LOAD;
      end
      S_FL_LOAD: begin
        in_stall = 1'b1;
        if (st.out_free) begin
          cmd.flush_load = 1'b1;
          state_next     = st.flush_last ? S_HEADER : S_FL_READ;
        end
      end
      default: begin
        state_next = S_HEADER;
      end
    endcase
    cmd.take = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fpr_datapath.sv =====
// Frame registers, checksum, payload memory and result register of the receiver.
`default_nettype none

module fpr_datapath #(
  parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  fpr_pkg::cmd_t                            cmd,
  output fpr_pkg::status_t                         st,
  input  wire logic [fpr_pkg::BYTE_W-1:0]          rx_byte,
  input  wire logic                                cfg_write,
  input  wire logic [fpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [fpr_pkg::BYTE_W-1:0]          cfg_data,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic                                     status,
  output logic [fpr_pkg::BYTE_W-1:0]               frame_address,
  output logic [fpr_pkg::BYTE_W-1:0]               command_code,
  output logic [fpr_pkg::COUNT_W-1:0]              payload_count,
  output logic                                     has_data,
  output logic [fpr_pkg::INDEX_W-1:0]              data_index,
  output logic [fpr_pkg::BYTE_W-1:0]               data_byte,
  output logic                                     last
);

  localparam int BW     = fpr_pkg::BYTE_W;
  localparam int CW     = fpr_pkg::COUNT_W;
  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [BW:0]   LEN_MAX     = (BW + 1)'(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] STORE_DEPTH = CW'(MAX_PAYLOAD);

  logic [BW-1:0] node_address;
  logic [BW-1:0] header_value;
  logic [BW-1:0] running_sum;
  logic [BW-1:0] frame_length;
  logic [CW-1:0] bytes_received;
  logic [BW-1:0] held_address;
  logic [BW-1:0] held_command;
  logic [CW-1:0] flush_idx;
  logic [BW-1:0] rd_data;
  logic [BW-1:0] store [MAX_PAYLOAD];

  logic [CW-1:0] bytes_inc;
  logic          store_wr;
  logic          single_load;

  assign bytes_inc = bytes_received + CW'(1);

  always_comb begin
    st.header_match  = (rx_byte == header_value);
    st.address_ok    = (rx_byte == '0) || (rx_byte == node_address);
    st.length_ok     = (rx_byte != '0) && ({1'b0, rx_byte} <= LEN_MAX);
    st.length_is_one = (frame_length == BW'(1));
    st.payload_done  = ({{(BW-CW){1'b0}}, bytes_inc} == (frame_length - BW'(1)));
    st.sum_match     = (running_sum == rx_byte);
    st.out_busy      = out_valid;
    st.out_free      = !out_valid || !out_stall;
    st.flush_last    = (({{(BW-CW){1'b0}}, flush_idx} + BW'(2)) == frame_length);
  end

  assign store_wr    = cmd.take && (cmd.op == fpr_pkg::OP_PAYLOAD) &&
                       (bytes_received < STORE_DEPTH);
  assign single_load = cmd.take && (cmd.op == fpr_pkg::OP_CHECK) &&
                       (!st.sum_match || st.length_is_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
      header_value <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fpr_pkg::REG_NODE_ADDRESS: node_address <= cfg_data;
        fpr_pkg::REG_HEADER_VALUE: header_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      frame_length   <= '0;
      bytes_received <= '0;
      held_address   <= '0;
      held_command   <= '0;
      flush_idx      <= '0;
    end else if (cmd.take) begin
      unique case (cmd.op)
        fpr_pkg::OP_HEADER: begin
          if (st.header_match) begin
            running_sum    <= '0;
            bytes_received <= '0;
          end
        end
        fpr_pkg::OP_ADDRESS: begin
          if (st.address_ok) begin
            held_address <= rx_byte;
            running_sum  <= rx_byte;
          end
        end
        fpr_pkg::OP_LENGTH: begin
          frame_length <= rx_byte;
          if (st.length_ok) running_sum <= running_sum + rx_byte;
        end
        fpr_pkg::OP_COMMAND: begin
          held_command   <= rx_byte;
          bytes_received <= '0;
          running_sum    <= running_sum + rx_byte;
        end
        fpr_pkg::OP_PAYLOAD: begin
          bytes_received <= bytes_inc;
          running_sum    <= running_sum + rx_byte;
        end
        fpr_pkg::OP_CHECK: begin
          flush_idx <= '0;
        end
        default: ;
      endcase
    end else if (cmd.flush_load) begin
      flush_idx <= flush_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) store[bytes_received[ADDR_W-1:0]] <= rx_byte;
    if (cmd.mem_read) rd_data <= store[flush_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (single_load || cmd.flush_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (single_load || cmd.flush_load) begin
      frame_address <= held_address;
      command_code  <= held_command;
      payload_count <= CW'(frame_length - BW'(1));
    end
    if (single_load) begin
      status     <= !st.sum_match;
      has_data   <= 1'b0;
      data_index <= '0;
      data_byte  <= '0;
      last       <= 1'b1;
    end else if (cmd.flush_load) begin
      status     <= 1'b0;
      has_data   <= 1'b1;
      data_index <= flush_idx[fpr_pkg::INDEX_W-1:0];
      data_byte  <= rd_data;
      last       <= st.flush_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/framed_packet_receiver.sv =====
// Top level of the framed packet receiver.
// Bytes are taken one per clock cycle while a frame is being received; the
// checksum byte is held off only while the previous result transaction still
// waits in the output register. A good frame with n payload bytes then sends
// its payload one byte at a time, since each byte is read from the single-port
// payload memory into a register before it is loaded into the output
// register, and no input is taken during that flush. Frames with a bad address
// or length are dropped silently, and a checksum mismatch or an empty payload
// gives a single result. No memory clearing is needed after reset.
`default_nettype none

module framed_packet_receiver #(
  parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [fpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [fpr_pkg::BYTE_W-1:0]       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [fpr_pkg::BYTE_W-1:0]       rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  status,
  output logic [fpr_pkg::BYTE_W-1:0]            frame_address,
  output logic [fpr_pkg::BYTE_W-1:0]            command_code,
  output logic [fpr_pkg::COUNT_W-1:0]           payload_count,
  output logic                                  has_data,
  output logic [fpr_pkg::INDEX_W-1:0]           data_index,
  output logic [fpr_pkg::BYTE_W-1:0]            data_byte,
  output logic                                  last
);

  fpr_pkg::cmd_t    cmd;
  fpr_pkg::status_t st;

  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  fpr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .rx_byte       (rx_byte),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .frame_address (frame_address),
    .command_code  (command_code),
    .payload_count (payload_count),
    .has_data      (has_data),
    .data_index    (data_index),
    .data_byte     (data_byte),
    .last          (last)
  );

endmodule

`default_nettype wire

// ===== rtl/fpr_checker.sv =====
// Port-level checker of the frame receiver and its binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module fpr_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             status,
  input wire logic [fpr_pkg::BYTE_W-1:0]       frame_address,
  input wire logic [fpr_pkg::BYTE_W-1:0]       command_code,
  input wire logic [fpr_pkg::COUNT_W-1:0]      payload_count,
  input wire logic                             has_data,
  input wire logic [fpr_pkg::INDEX_W-1:0]      data_index,
  input wire logic [fpr_pkg::BYTE_W-1:0]       data_byte,
  input wire logic                             last
);

  logic [3*fpr_pkg::BYTE_W+fpr_pkg::COUNT_W+fpr_pkg::INDEX_W+2:0] out_payload;

  assign out_payload = {status, frame_address, command_code, payload_count,
                        has_data, data_index, data_byte, last};

  // A stalled result transaction keeps its whole payload.
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_payload))

  // An error result never carries payload data.
  `ASSERT_NEVER(a_err_no_data, clk, rst, out_valid && status && has_data)

  // A result without data always closes its frame.
  `ASSERT_CLK(a_nodata_last, clk, rst, out_valid && !has_data |-> last)

  // While a payload flush is still running, input is held off.
  `ASSERT_CLK(a_flush_stall, clk, rst, out_valid && has_data && !last |-> in_stall)

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the framed packet receiver with a frame-tracking scoreboard.
module tb;

  localparam int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic       status;
    logic [7:0] frame_address;
    logic [7:0] command_code;
    logic [5:0] payload_count;
    logic       has_data;
    logic [4:0] data_index;
    logic [7:0] data_byte;
    logic       last;
  } rx_result_t;

  typedef enum logic [2:0] {
    HUNT_HEADER, GET_ADDRESS, GET_LENGTH, GET_COMMAND, GET_PAYLOAD, GET_CHECKSUM
  } rx_phase_t;

  typedef enum {GOOD_FRAME, BAD_CHECKSUM, BAD_ADDRESS, BAD_LENGTH} frame_kind_t;

  class frame_tracker_t;
    logic [7:0] node_address;
    logic [7:0] header_value;
    rx_phase_t  phase;
    logic [7:0] running_sum;
    logic [7:0] frame_length;
    logic [7:0] held_address;
    logic [7:0] held_command;
    logic [5:0] bytes_seen;
    logic [7:0] payload [MAX_PAYLOAD];
    rx_result_t expected_results [$];
    int         mismatches;

    function new();
      node_address = 8'h00;
      header_value = 8'hFF;
      phase = HUNT_HEADER;
      running_sum = 8'h00;
      frame_length = 8'h00;
      held_address = 8'h00;
      held_command = 8'h00;
      bytes_seen = 6'd0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [fpr_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] value);
      if (idx == fpr_pkg::REG_NODE_ADDRESS) begin
        node_address = value;
      end else if (idx == fpr_pkg::REG_HEADER_VALUE) begin
        header_value = value;
      end
    endfunction

    function void push_result(logic st, logic has, int idx, logic [7:0] value, logic fin);
      rx_result_t r;
      logic [7:0] count;
      count = frame_length - 8'd1;
      r.status = st;
      r.frame_address = held_address;
      r.command_code = held_command;
      r.payload_count = count[5:0];
      r.has_data = has;
      r.data_index = idx[4:0];
      r.data_byte = value;
      r.last = fin;
      expected_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      int count;
      int i;
      case (phase)
        HUNT_HEADER: begin
          if (b == header_value) begin
            running_sum = 8'h00;
            bytes_seen = 6'd0;
            phase = GET_ADDRESS;
          end
        end
        GET_ADDRESS: begin
          if (b == 8'h00 || b == node_address) begin
            held_address = b;
            running_sum = b;
            phase = GET_LENGTH;
          end else begin
            phase = HUNT_HEADER;
          end
        end
        GET_LENGTH: begin
          frame_length = b;
          if (b == 8'h00 || int'(b) > MAX_PAYLOAD + 1) begin
            phase = HUNT_HEADER;
          end else begin
            running_sum = running_sum + b;
            phase = GET_COMMAND;
          end
        end
        GET_COMMAND: begin
          held_command = b;
          bytes_seen = 6'd0;
          running_sum = running_sum + b;
          phase = (frame_length == 8'd1) ? GET_CHECKSUM : GET_PAYLOAD;
        end
        GET_PAYLOAD: begin
          if (int'(bytes_seen) < MAX_PAYLOAD) payload[bytes_seen[4:0]] = b;
          bytes_seen = bytes_seen + 6'd1;
          running_sum = running_sum + b;
          if ({2'b00, bytes_seen} + 8'd1 == frame_length) phase = GET_CHECKSUM;
        end
        GET_CHECKSUM: begin
          phase = HUNT_HEADER;
          if (running_sum == b) begin
            count = int'(frame_length) - 1;
            if (count > MAX_PAYLOAD) count = MAX_PAYLOAD;
            if (count == 0) begin
              push_result(1'b0, 1'b0, 0, 8'h00, 1'b1);
            end else begin
              for (i = 0; i < count; i++) begin
                push_result(1'b0, 1'b1, i, payload[i[4:0]], i == count - 1);
              end
            end
          end else begin
            push_result(1'b1, 1'b0, 0, 8'h00, 1'b1);
          end
        end
        default: phase = HUNT_HEADER;
      endcase
    endfunction

    function string describe(rx_result_t r);
      return $sformatf({"status=%0d addr=%02h cmd=%02h count=%0d ",
                        "has=%0d idx=%0d data=%02h last=%0d"},
                       r.status, r.frame_address, r.command_code, r.payload_count,
                       r.has_data, r.data_index, r.data_byte, r.last);
    endfunction

    function void compare_result(rx_result_t got);
      rx_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %s", describe(want));
            $display("                 actual   %s", describe(got));
          end
        end
      end
    endfunction

    function bit drained();
      return expected_results.size() == 0;
    endfunction
  endclass

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fpr_pkg::BYTE_W-1:0]      cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [fpr_pkg::BYTE_W-1:0]      rx_byte = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            status;
  logic [fpr_pkg::BYTE_W-1:0]      frame_address;
  logic [fpr_pkg::BYTE_W-1:0]      command_code;
  logic [fpr_pkg::COUNT_W-1:0]     payload_count;
  logic                            has_data;
  logic [fpr_pkg::INDEX_W-1:0]     data_index;
  logic [fpr_pkg::BYTE_W-1:0]      data_byte;
  logic                            last;

  int         idle_pct = 0;
  int         stall_pct = 0;
  int         hold_request = 0;
  int         hold_left = 0;
  logic [7:0] cur_node = 8'h00;
  logic [7:0] cur_header = 8'hFF;
  logic [7:0] rx_stream [$];

  frame_tracker_t tracker;

  framed_packet_receiver dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .frame_address(frame_address),
    .command_code(command_code),
    .payload_count(payload_count),
    .has_data(has_data),
    .data_index(data_index),
    .data_byte(data_byte),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[framed_packet_receiver] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tracker.compare_result({status, frame_address, command_code, payload_count,
                                has_data, data_index, data_byte, last});
      end
      if (in_valid && !in_stall) tracker.take_byte(rx_byte);
    end
  end

  task automatic set_reg(input logic [fpr_pkg::CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.write_reg(idx, value);
    if (idx == fpr_pkg::REG_NODE_ADDRESS) begin
      cur_node = value;
    end else begin
      cur_header = value;
    end
  endtask

  task automatic send_byte(input logic [7:0] value);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_stream();
    while (rx_stream.size() > 0) send_byte(rx_stream.pop_front());
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int waited = 0;
    while (!tracker.drained() && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void add_frame(frame_kind_t kind, logic [7:0] addr, logic [7:0] len);
    logic [7:0] sum;
    logic [7:0] cmd;
    logic [7:0] value;
    int i;
    rx_stream.push_back(cur_header);
    rx_stream.push_back(addr);
    if (kind == BAD_ADDRESS) return;
    rx_stream.push_back(len);
    if (kind == BAD_LENGTH) return;
    cmd = 8'($urandom_range(255));
    sum = addr + len + cmd;
    rx_stream.push_back(cmd);
    for (i = 1; i < int'(len); i++) begin
      value = 8'($urandom_range(255));
      rx_stream.push_back(value);
      sum = sum + value;
    end
    if (kind == BAD_CHECKSUM) sum = sum + 8'($urandom_range(255, 1));
    rx_stream.push_back(sum);
  endfunction

  function automatic void add_random_frame();
    logic [7:0] addr;
    logic [7:0] len;
    int pick;
    if ($urandom_range(99) < 15) begin
      do addr = 8'($urandom_range(255)); while (addr == cur_header);
      rx_stream.push_back(addr);
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      do addr = 8'($urandom_range(255)); while (addr == 8'h00 || addr == cur_node);
      add_frame(BAD_ADDRESS, addr, 8'h00);
    end else if (pick == 1) begin
      len = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, MAX_PAYLOAD + 2));
      add_frame(BAD_LENGTH, 8'h00, len);
    end else begin
      addr = $urandom_range(1) ? cur_node : 8'h00;
      len = ($urandom_range(7) == 0) ? 8'($urandom_range(MAX_PAYLOAD + 1, 10))
                                     : 8'($urandom_range(9, 1));
      add_frame((pick == 2) ? BAD_CHECKSUM : GOOD_FRAME, addr, len);
    end
  endfunction

  initial begin : stimulus
    logic [7:0] node_cfg [4] = '{8'h3C, 8'h00, 8'h00, 8'hC3};
    logic [7:0] header_cfg [4] = '{8'hA5, 8'h00, 8'h00, 8'h7E};
    int idle_cfg [4] = '{0, 52, 0, 19};
    int stall_cfg [4] = '{0, 0, 52, 19};
    int p;
    tracker = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_reg(fpr_pkg::REG_NODE_ADDRESS, 8'hFF);
    set_reg(fpr_pkg::REG_HEADER_VALUE, 8'hFF);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'h12);
    add_frame(GOOD_FRAME, 8'h00, 8'd1);
    add_frame(BAD_CHECKSUM, 8'hFF, 8'd2);
    add_frame(BAD_ADDRESS, 8'h07, 8'd0);
    add_frame(BAD_LENGTH, 8'h00, 8'd0);
    add_frame(BAD_LENGTH, 8'hFF, 8'(MAX_PAYLOAD + 2));
    add_frame(GOOD_FRAME, 8'hFF, 8'd3);
    send_stream();
    wait_drained();

    node_cfg[2] = 8'($urandom_range(255));
    header_cfg[2] = 8'($urandom_range(255));
    for (p = 0; p < 4; p++) begin
      set_reg(fpr_pkg::REG_NODE_ADDRESS, node_cfg[p]);
      set_reg(fpr_pkg::REG_HEADER_VALUE, header_cfg[p]);
      idle_pct = idle_cfg[p];
      stall_pct = stall_cfg[p];
      while (rx_stream.size() < 8) add_random_frame();
      send_stream();
      wait_drained();
    end

    // The output side holds off long enough for the full payload flush to back up the input.
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 400;
    add_frame(GOOD_FRAME, cur_node, 8'(MAX_PAYLOAD + 1));
    repeat (1) add_random_frame();
    send_stream();
    wait_drained();

    if (!tracker.drained()) begin
      $display("%0d expected results never arrived", tracker.expected_results.size());
    end
    if (tracker.mismatches == 0 && tracker.drained()) begin
      $display("[framed_packet_receiver] OK");
    end else begin
      $display("[framed_packet_receiver] ERROR");
    end
    $finish;
  end

endmodule
